// ----- hw/rtl/cvt_pkg.sv -----
// ----------------------------------------------------------------------------
// cvt_pkg
// Shared types, codes and constants of the constant-velocity track update.
// ----------------------------------------------------------------------------
`default_nettype none

package cvt_pkg;

	localparam int unsigned AXES       = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned STEP_W     = 6;

	localparam logic [1:0] AXIS_LAST = 2'd2;

	localparam logic [STEP_W-1:0] MUL_STEPS = 6'd32;
	localparam logic [STEP_W-1:0] DIV_STEPS = 6'd33;

	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	localparam logic [7:0]  CONFIRM_HITS_RST = 8'd3;
	localparam logic [7:0]  LOST_MISSES_RST  = 8'd5;
	localparam logic [15:0] MAX_MISSES_RST   = 16'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONFIRM_HITS = 2'd0,
		CFG_LOST_MISSES  = 2'd1,
		CFG_MAX_MISSES   = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_UPDATE  = 2'd1,
		CMD_PREDICT = 2'd2,
		CMD_MISS    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		LIFE_TENTATIVE = 2'd0,
		LIFE_CONFIRMED = 2'd1,
		LIFE_LOST      = 2'd2
	} life_t;

	// request to the shared arithmetic unit
	typedef struct packed {
		logic               start;
		logic               mul;
		logic signed [32:0] a;
		logic signed [31:0] b;
		logic [31:0]        dt;
	} arith_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} arith_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cvt_if.sv -----
// ----------------------------------------------------------------------------
// cvt_if
// Valid/ready channels for measurement requests and track reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvt_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [31:0] meas_x;
	logic signed [31:0] meas_y;
	logic signed [31:0] meas_z;
	logic [31:0]        time_in;

	modport source (output valid, command, meas_x, meas_y, meas_z, time_in, input ready);
	modport sink (input valid, command, meas_x, meas_y, meas_z, time_in, output ready);
endinterface

interface cvt_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         lifecycle;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_z;
	logic [15:0]        hits;
	logic [15:0]        misses;
	logic [15:0]        track_age;
	logic               should_delete;

	modport source (output valid, lifecycle, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		hits, misses, track_age, should_delete, input ready);
	modport sink (input valid, lifecycle, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		hits, misses, track_age, should_delete, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cvt_arith.sv -----
// ----------------------------------------------------------------------------
// cvt_arith
// Shared shift-add multiplier and restoring divider on one 66-bit adder,
// one bit per cycle, with 32-bit signed saturation of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cvt_arith import cvt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  arith_req_t req,
	output arith_rsp_t rsp
);

	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic              mul_q;
	logic              neg_q;
	logic [65:0]       acc_q;
	logic [65:0]       opnd_q;
	logic [31:0]       dt_q;
	logic [31:0]       rem_q;
	logic [32:0]       quo_q;
	logic [31:0]       result_q;

	logic [65:0] add_a;
	logic [65:0] add_b;
	logic        cin;
	logic [65:0] sum;
	logic        ge;
	logic [32:0] a_u;
	logic [32:0] a_mag;
	logic [31:0] mul_sat;
	logic [31:0] div_sat;

	always_comb begin
		if (mul_q) begin
			add_a = acc_q;
			add_b = dt_q[0] ? opnd_q : 66'd0;
			cin   = 1'b0;
		end else begin
			// trial subtract of the divisor from the shifted remainder
			add_a = {33'd0, rem_q, quo_q[32]};
			add_b = ~{34'd0, dt_q};
			cin   = 1'b1;
		end
		sum = add_a + add_b + {65'd0, cin};
		ge  = ~sum[65];
	end

	assign a_u   = req.a;
	assign a_mag = a_u[32] ? (~a_u + 33'd1) : a_u;

	always_comb begin
		if ((&acc_q[65:31]) || !(|acc_q[65:31])) begin
			mul_sat = acc_q[31:0];
		end else begin
			mul_sat = acc_q[65] ? S32_MIN : S32_MAX;
		end
		if (neg_q) begin
			if (quo_q[32] || (quo_q[31] && (|quo_q[30:0]))) begin
				div_sat = S32_MIN;
			end else begin
				div_sat = ~quo_q[31:0] + 32'd1;
			end
		end else begin
			div_sat = (quo_q[32] || quo_q[31]) ? S32_MAX : quo_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= busy_q && (cnt_q == 6'd1) && !req.start;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.mul ? MUL_STEPS : DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mul_q  <= req.mul;
			neg_q  <= req.a[32];
			dt_q   <= req.dt;
			acc_q  <= {{33{req.a[32]}}, req.a};
			opnd_q <= {{34{req.b[31]}}, req.b};
			quo_q  <= a_mag;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (mul_q) begin
				acc_q  <= sum;
				opnd_q <= {opnd_q[64:0], 1'b0};
				dt_q   <= {1'b0, dt_q[31:1]};
			end else begin
				rem_q <= ge ? sum[31:0] : {rem_q[30:0], quo_q[32]};
				quo_q <= {quo_q[31:0], ge};
			end
		end
		if (fin_q) begin
			result_q <= mul_q ? mul_sat : div_sat;
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

`default_nettype wire

// ----- hw/rtl/constant_velocity_track_update.sv -----
// ----------------------------------------------------------------------------
// constant_velocity_track_update
// Flow: start and mark-missed requests go from idle straight to the done state;
//   update and predict with elapsed time take the three axes in turn through
//   one bit-serial divider/multiplier (33 or 32 steps each, with prepare, issue
//   and wait states around each axis); without elapsed time they skip it.
// Handshake: ready only while idle; the done state stalls until the report register is free.
// Reset: asynchronous; empty track and default register values at once.
// ----------------------------------------------------------------------------
`default_nettype none

module constant_velocity_track_update import cvt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	cvt_in_if.sink                meas,
	cvt_out_if.source             report
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PREP  = 5'b00010,
		S_ISSUE = 5'b00100,
		S_WAIT  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t      state_q;
	logic [1:0]  axis_q;

	logic [7:0]  confirm_hits_q;
	logic [7:0]  lost_misses_q;
	logic [15:0] max_misses_q;

	life_t       life_q;
	logic [31:0] pos_q [AXES];
	logic [31:0] vel_q [AXES];
	logic [31:0] last_time_q;
	logic [15:0] hits_q;
	logic [15:0] misses_q;
	logic [15:0] age_q;

	cmd_t        cmd_q;
	logic [31:0] meas_q [AXES];
	logic [31:0] time_q;
	logic [31:0] dt_q;
	logic        adv_q;
	logic [31:0] res_q [AXES];
	logic [32:0] opa_q;
	logic [31:0] opb_q;

	logic        out_valid_q;
	logic [1:0]  out_life_q;
	logic [31:0] out_pos_q [AXES];
	logic [31:0] out_vel_q [AXES];
	logic [15:0] out_hits_q;
	logic [15:0] out_misses_q;
	logic [15:0] out_age_q;
	logic        out_del_q;

	arith_req_t  req;
	arith_rsp_t  rsp;

	logic        accept;
	logic        commit;
	logic        needs_arith;
	logic [15:0] hits_inc;
	logic [15:0] misses_inc;
	logic [15:0] age_inc;

	life_t       n_life;
	logic [31:0] n_pos [AXES];
	logic [31:0] n_vel [AXES];
	logic [31:0] n_last;
	logic [15:0] n_hits;
	logic [15:0] n_misses;
	logic [15:0] n_age;
	logic        n_del;

	cvt_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign meas.ready = (state_q == S_IDLE);
	assign accept     = meas.valid && meas.ready;
	assign commit     = (state_q == S_DONE) && (!out_valid_q || report.ready);

	assign needs_arith = (meas.command == CMD_UPDATE) || (meas.command == CMD_PREDICT);

	always_comb begin
		req.start = (state_q == S_ISSUE);
		req.mul   = (cmd_q == CMD_PREDICT);
		req.a     = opa_q;
		req.b     = opb_q;
		req.dt    = dt_q;
	end

	assign hits_inc   = (hits_q == CNT_MAX) ? hits_q : hits_q + 16'd1;
	assign misses_inc = (misses_q == CNT_MAX) ? misses_q : misses_q + 16'd1;
	assign age_inc    = (age_q == CNT_MAX) ? age_q : age_q + 16'd1;

	always_comb begin
		n_life   = life_q;
		n_pos    = pos_q;
		n_vel    = vel_q;
		n_last   = last_time_q;
		n_hits   = hits_q;
		n_misses = misses_q;
		n_age    = age_q;
		case (cmd_q)
			CMD_START: begin
				n_pos    = meas_q;
				n_vel    = '{default: 32'd0};
				n_last   = time_q;
				n_hits   = 16'd1;
				n_misses = 16'd0;
				n_age    = 16'd1;
				n_life   = LIFE_TENTATIVE;
			end
			CMD_UPDATE: begin
				if (adv_q) begin
					n_vel = res_q;
				end
				n_pos    = meas_q;
				n_last   = time_q;
				n_hits   = hits_inc;
				n_misses = 16'd0;
				n_age    = age_inc;
				if (life_q == LIFE_TENTATIVE && hits_inc >= {8'd0, confirm_hits_q}) begin
					n_life = LIFE_CONFIRMED;
				end
			end
			CMD_PREDICT: begin
				if (adv_q) begin
					n_pos  = res_q;
					n_last = time_q;
				end
				n_age = age_inc;
			end
			CMD_MISS: begin
				n_misses = misses_inc;
				if (misses_inc > {8'd0, lost_misses_q}) begin
					n_life = LIFE_LOST;
				end
			end
			default: begin
				n_life = life_q;
			end
		endcase
		n_del = (n_misses > max_misses_q) || (n_life == LIFE_LOST);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= 2'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						axis_q <= 2'd0;
						// skip the arithmetic for start and miss, and when time has not advanced
						if (needs_arith && (meas.time_in > last_time_q)) begin
							state_q <= S_PREP;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_PREP: begin
					state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (rsp.done) begin
						if (axis_q == AXIS_LAST) begin
							state_q <= S_DONE;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= S_PREP;
						end
					end
				end
				S_DONE: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_hits_q <= CONFIRM_HITS_RST;
			lost_misses_q  <= LOST_MISSES_RST;
			max_misses_q   <= MAX_MISSES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CONFIRM_HITS: confirm_hits_q <= cfg_data[7:0];
				CFG_LOST_MISSES:  lost_misses_q  <= cfg_data[7:0];
				CFG_MAX_MISSES:   max_misses_q   <= cfg_data;
				default: begin
					max_misses_q <= max_misses_q;
				end
			endcase
		end
	end

	// track state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q      <= LIFE_TENTATIVE;
			pos_q       <= '{default: 32'd0};
			vel_q       <= '{default: 32'd0};
			last_time_q <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			age_q       <= '0;
		end else if (commit) begin
			life_q      <= n_life;
			pos_q       <= n_pos;
			vel_q       <= n_vel;
			last_time_q <= n_last;
			hits_q      <= n_hits;
			misses_q    <= n_misses;
			age_q       <= n_age;
		end
	end

	// request capture and per-axis operands
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd_t'(meas.command);
			meas_q[0] <= meas.meas_x;
			meas_q[1] <= meas.meas_y;
			meas_q[2] <= meas.meas_z;
			time_q    <= meas.time_in;
			dt_q      <= meas.time_in - last_time_q;
			adv_q     <= meas.time_in > last_time_q;
		end
		if (state_q == S_PREP) begin
			if (cmd_q == CMD_UPDATE) begin
				opa_q <= {meas_q[axis_q][31], meas_q[axis_q]}
					- {pos_q[axis_q][31], pos_q[axis_q]};
			end else begin
				opa_q <= {pos_q[axis_q][31], pos_q[axis_q]};
			end
			opb_q <= vel_q[axis_q];
		end
		if (state_q == S_WAIT && rsp.done) begin
			res_q[axis_q] <= rsp.result;
		end
	end

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_life_q   <= n_life;
			out_pos_q    <= n_pos;
			out_vel_q    <= n_vel;
			out_hits_q   <= n_hits;
			out_misses_q <= n_misses;
			out_age_q    <= n_age;
			out_del_q    <= n_del;
		end
	end

	assign report.valid         = out_valid_q;
	assign report.lifecycle     = out_life_q;
	assign report.pos_x         = out_pos_q[0];
	assign report.pos_y         = out_pos_q[1];
	assign report.pos_z         = out_pos_q[2];
	assign report.vel_x         = out_vel_q[0];
	assign report.vel_y         = out_vel_q[1];
	assign report.vel_z         = out_vel_q[2];
	assign report.hits          = out_hits_q;
	assign report.misses        = out_misses_q;
	assign report.track_age     = out_age_q;
	assign report.should_delete = out_del_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cvt_checker.sv -----
// ----------------------------------------------------------------------------
// cvt_checker
// Port-level checks of the track update block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cvt_checker import cvt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  in_command,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_lifecycle,
	input logic [31:0] out_pos_x,
	input logic [31:0] out_vel_x,
	input logic [31:0] out_vel_y,
	input logic [31:0] out_vel_z,
	input logic [15:0] out_hits,
	input logic [15:0] out_misses,
	input logic [15:0] out_track_age,
	input logic        out_should_delete
);

	// hold a stalled report
	a_report_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({out_lifecycle, out_pos_x, out_vel_x, out_hits,
				out_misses, out_track_age, out_should_delete}))
		else $error("stalled report changed");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_lost_deletes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_lifecycle == LIFE_LOST |-> out_should_delete)
		else $error("lost track without delete flag");

	// a start reports a fresh track, through the done state and the report register, when the report side is free
	a_start_report: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_command == CMD_START && !out_valid |=> ##1
			out_valid && out_hits == 16'd1 && out_track_age == 16'd1
			&& out_misses == 16'd0 && out_lifecycle == LIFE_TENTATIVE
			&& out_vel_x == 32'd0 && out_vel_y == 32'd0 && out_vel_z == 32'd0)
		else $error("start did not report a fresh track");

endmodule

bind constant_velocity_track_update cvt_checker u_cvt_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (meas.valid),
	.in_ready          (meas.ready),
	.in_command        (meas.command),
	.out_valid         (report.valid),
	.out_ready         (report.ready),
	.out_lifecycle     (report.lifecycle),
	.out_pos_x         (report.pos_x),
	.out_vel_x         (report.vel_x),
	.out_vel_y         (report.vel_y),
	.out_vel_z         (report.vel_z),
	.out_hits          (report.hits),
	.out_misses        (report.misses),
	.out_track_age     (report.track_age),
	.out_should_delete (report.should_delete)
);

`default_nettype wire
